// ===== sv/mlp_pkg.sv =====
package mlp_pkg;

  // Network shape
  localparam int H1 = 8;
  localparam int H2 = 4;
  localparam int SIG_SIZE = 256;

  // Flat store layout
  localparam int W1_BASE = 0;
  localparam int B1_BASE = 2 * H1;
  localparam int W2_BASE = 3 * H1;
  localparam int B2_BASE = W2_BASE + H1 * H2;
  localparam int W3_BASE = B2_BASE + H2;
  localparam int B3_BASE = W3_BASE + H2;
  localparam int DEPTH   = B3_BASE + 1;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int DATA_W  = 16;
  localparam int IDX_W   = 7;
  localparam int QW      = 13;

  localparam int MAXN  = (H1 > H2) ? ((H1 > 2) ? H1 : 2) : ((H2 > 2) ? H2 : 2);
  localparam int CNT_W = $clog2(MAXN + 1);
  localparam int H1_IW = (H1 > 1) ? $clog2(H1) : 1;
  localparam int H2_IW = (H2 > 1) ? $clog2(H2) : 1;
  localparam int SIG_IW = $clog2(SIG_SIZE);

  // Command codes
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_INFER = 2'd2;
  localparam logic [1:0] CMD_TRAIN = 2'd3;

  // Sequencer states
  localparam int ST_W = 5;
  localparam logic [ST_W-1:0] S_IDLE  = 5'd0;
  localparam logic [ST_W-1:0] S_WRITE = 5'd1;
  localparam logic [ST_W-1:0] S_READ  = 5'd2;
  localparam logic [ST_W-1:0] S_L1    = 5'd3;
  localparam logic [ST_W-1:0] S_L2    = 5'd4;
  localparam logic [ST_W-1:0] S_L3    = 5'd5;
  localparam logic [ST_W-1:0] S_ERR   = 5'd6;
  localparam logic [ST_W-1:0] S_G2    = 5'd7;
  localparam logic [ST_W-1:0] S_G1    = 5'd8;
  localparam logic [ST_W-1:0] S_UW3   = 5'd9;
  localparam logic [ST_W-1:0] S_UB3   = 5'd10;
  localparam logic [ST_W-1:0] S_UW2   = 5'd11;
  localparam logic [ST_W-1:0] S_UB2   = 5'd12;
  localparam logic [ST_W-1:0] S_UW1   = 5'd13;
  localparam logic [ST_W-1:0] S_UB1   = 5'd14;
  localparam logic [ST_W-1:0] S_DONE  = 5'd15;

  typedef struct packed {
    logic              accept;
    logic [ST_W-1:0]   job;
    logic [1:0]        ph;
    logic [CNT_W-1:0]  n;
    logic [CNT_W-1:0]  k;
    logic [ADDR_W-1:0] addr;
  } mlp_cmd_t;

  // Sigmoid table, built at elaboration
  typedef logic [QW-1:0] sig_tab_t [SIG_SIZE];

  localparam longint unsigned Q30_ONE = 64'd1 << 30;
  localparam longint unsigned EXP_M1  = 64'd395007542;

  // Shift-and-subtract quotient; used only while building the table
  function automatic longint unsigned udiv(input longint unsigned num,
                                           input longint unsigned dvs);
    longint unsigned q, r;
    q = 0;
    r = 0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], num[b]};
      q = q << 1;
      if (r >= dvs) begin
        r = r - dvs;
        q = q | 64'd1;
      end
    end
    return q;
  endfunction

  function automatic sig_tab_t build_sig_tab();
    sig_tab_t t;
    longint xc;
    longint unsigned mag, nn, f, term, e, den, sp;
    longint sum;
    for (int k = 0; k < SIG_SIZE; k++) begin
      xc = longint'(udiv(longint'(k) * 65536 + 32768, SIG_SIZE)) - 32768;
      mag = (xc < 0) ? longint'(-xc) : longint'(xc);
      nn = mag >> 12;
      f = mag & 64'd4095;
      sum = longint'(Q30_ONE);
      term = Q30_ONE;
      for (int i = 1; i <= 12; i++) begin
        term = udiv((term * f) >> 12, longint'(i));
        if ((i & 1) == 1) sum = sum - longint'(term);
        else sum = sum + longint'(term);
      end
      e = longint'(sum);
      for (longint unsigned j = 0; j < nn; j++) begin
        e = (e * EXP_M1 + (Q30_ONE >> 1)) >> 30;
      end
      den = Q30_ONE + e;
      sp = udiv((64'd4096 << 30) + (den >> 1), den);
      t[k] = (xc >= 0) ? QW'(sp) : QW'(64'd4096 - sp);
    end
    return t;
  endfunction

  localparam sig_tab_t SIG_TAB = build_sig_tab();

endpackage

// ===== sv/mlp_ram.sv =====
module mlp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/mlp_ctrl.sv =====
module mlp_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [1:0]       in_command,
  input  logic             out_stall,
  output logic             in_stall,
  output logic             out_valid,
  output mlp_pkg::mlp_cmd_t cmd
);
  import mlp_pkg::*;

  logic [ST_W-1:0]  state_r, state_nxt;
  logic [1:0]       ph_r, ph_nxt;
  logic [CNT_W-1:0] n_r, n_nxt, k_r, k_nxt;
  logic             train_r, train_nxt;
  logic [CNT_W-1:0] n_last, k_last;
  logic [ST_W-1:0]  after;
  logic             is_mac, is_upd;
  int               addr_i;

  // loop bounds and successor of each pass
  always_comb begin
    n_last = '0;
    k_last = '0;
    after  = S_DONE;
    is_mac = 1'b0;
    is_upd = 1'b0;
    unique case (state_r)
      S_L1:  begin n_last = CNT_W'(H1-1); k_last = CNT_W'(2);  after = S_L2; is_mac = 1'b1; end
      S_L2:  begin n_last = CNT_W'(H2-1); k_last = CNT_W'(H1); after = S_L3; is_mac = 1'b1; end
      S_L3:  begin
        k_last = CNT_W'(H2);
        after = train_r ? S_ERR : S_DONE;
        is_mac = 1'b1;
      end
      S_G2:  begin n_last = CNT_W'(H2-1); after = S_G1; is_mac = 1'b1; end
      S_G1:  begin n_last = CNT_W'(H1-1); k_last = CNT_W'(H2-1); after = S_UW3; is_mac = 1'b1; end
      S_UW3: begin n_last = CNT_W'(H2-1); after = S_UB3; is_upd = 1'b1; end
      S_UB3: begin after = S_UW2; is_upd = 1'b1; end
      S_UW2: begin n_last = CNT_W'(H1-1); k_last = CNT_W'(H2-1); after = S_UB2; is_upd = 1'b1; end
      S_UB2: begin k_last = CNT_W'(H2-1); after = S_UW1; is_upd = 1'b1; end
      S_UW1: begin n_last = CNT_W'(1); k_last = CNT_W'(H1-1); after = S_UB1; is_upd = 1'b1; end
      S_UB1: begin k_last = CNT_W'(H1-1); after = S_DONE; is_upd = 1'b1; end
      default: ;
    endcase
  end

  // store address of the current term
  always_comb begin
    addr_i = 0;
    unique case (state_r)
      S_L1:  addr_i = (k_r == '0) ? B1_BASE + int'(n_r)
                                  : W1_BASE + (int'(k_r) - 1) * H1 + int'(n_r);
      S_L2:  addr_i = (k_r == '0) ? B2_BASE + int'(n_r)
                                  : W2_BASE + (int'(k_r) - 1) * H2 + int'(n_r);
      S_L3:  addr_i = (k_r == '0) ? B3_BASE : W3_BASE + int'(k_r) - 1;
      S_G2:  addr_i = W3_BASE + int'(n_r);
      S_G1:  addr_i = W2_BASE + int'(n_r) * H2 + int'(k_r);
      S_UW3: addr_i = W3_BASE + int'(n_r);
      S_UB3: addr_i = B3_BASE;
      S_UW2: addr_i = W2_BASE + int'(n_r) * H2 + int'(k_r);
      S_UB2: addr_i = B2_BASE + int'(k_r);
      S_UW1: addr_i = W1_BASE + int'(n_r) * H1 + int'(k_r);
      S_UB1: addr_i = B1_BASE + int'(k_r);
      default: addr_i = 0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    ph_nxt    = ph_r;
    n_nxt     = n_r;
    k_nxt     = k_r;
    train_nxt = train_r;
    if (state_r == S_IDLE) begin
      if (in_valid) begin
        ph_nxt    = '0;
        n_nxt     = '0;
        k_nxt     = '0;
        train_nxt = (in_command == CMD_TRAIN);
        unique case (in_command)
          CMD_WRITE: state_nxt = S_WRITE;
          CMD_READ:  state_nxt = S_READ;
          CMD_INFER: state_nxt = S_L1;
          CMD_TRAIN: state_nxt = S_L1;
          default:   state_nxt = S_L1;
        endcase
      end
    end else if (state_r == S_WRITE) begin
      state_nxt = S_DONE;
    end else if (state_r == S_READ) begin
      ph_nxt = ph_r + 2'd1;
      if (ph_r == 2'd1) state_nxt = S_DONE;
    end else if (state_r == S_ERR) begin
      ph_nxt = ph_r + 2'd1;
      if (ph_r == 2'd3) state_nxt = S_G2;
    end else if (state_r == S_DONE) begin
      // hold the result until taken
      if (!out_stall) state_nxt = S_IDLE;
    end else if (is_mac) begin
      priority if (ph_r == 2'd3) begin
        ph_nxt = '0;
        k_nxt  = '0;
        if (n_r == n_last) begin
          n_nxt = '0;
          state_nxt = after;
        end else begin
          n_nxt = n_r + 1'b1;
        end
      end else if (ph_r == 2'd2) begin
        if (k_r == k_last) begin
          ph_nxt = 2'd3;
        end else begin
          ph_nxt = '0;
          k_nxt = k_r + 1'b1;
        end
      end else begin
        ph_nxt = ph_r + 2'd1;
      end
    end else if (is_upd) begin
      if (ph_r == 2'd2) begin
        ph_nxt = '0;
        if (k_r == k_last) begin
          k_nxt = '0;
          if (n_r == n_last) begin
            n_nxt = '0;
            state_nxt = after;
          end else begin
            n_nxt = n_r + 1'b1;
          end
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end else begin
        ph_nxt = ph_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ph_r    <= '0;
      n_r     <= '0;
      k_r     <= '0;
      train_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ph_r    <= ph_nxt;
      n_r     <= n_nxt;
      k_r     <= k_nxt;
      train_r <= train_nxt;
    end
  end

  assign in_stall   = (state_r != S_IDLE);
  assign out_valid  = (state_r == S_DONE);
  assign cmd.accept = (state_r == S_IDLE) && in_valid;
  assign cmd.job    = state_r;
  assign cmd.ph     = ph_r;
  assign cmd.n      = n_r;
  assign cmd.k      = k_r;
  assign cmd.addr   = ADDR_W'(addr_i);

endmodule

// ===== sv/mlp_dp.sv =====
module mlp_dp (
  input  logic                     clk,
  input  logic                     rst_n,
  input  mlp_pkg::mlp_cmd_t        cmd,
  input  logic [mlp_pkg::IDX_W-1:0] in_word_index,
  input  logic signed [15:0]       in_word_value,
  input  logic signed [15:0]       in_feature_x,
  input  logic signed [15:0]       in_feature_y,
  input  logic [12:0]              in_target_value,
  input  logic                     cfg_we,
  input  logic [12:0]              cfg_wdata,
  output logic [12:0]              out_prediction,
  output logic signed [15:0]       out_word_readback,
  output logic [12:0]              out_squared_error
);
  import mlp_pkg::*;

  localparam int ACC_W = 36;
  localparam int P_W   = 34;
  localparam int Q_W   = 48;

  function automatic logic signed [ACC_W-1:0] rnd12(input logic signed [ACC_W-1:0] v);
    return (v + ACC_W'(2048)) >>> 12;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [Q_W-1:0] v);
    logic signed [15:0] r;
    if (v > Q_W'(32767)) r = 16'sh7fff;
    else if (v < -Q_W'(32768)) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

  function automatic logic signed [15:0] relu(input logic signed [15:0] v);
    return (v > 16'sd0) ? v : 16'sd0;
  endfunction

  localparam logic signed [16:0] ONE_Q = 17'sd4096;

  logic [IDX_W-1:0]         idx_r;
  logic signed [15:0]       val_r;
  logic signed [15:0]       feat_r [2];
  logic [12:0]              tgt_r;
  logic [12:0]              pred_r, sq_r;
  logic signed [15:0]       rb_r;
  logic [12:0]              lr_r;
  logic signed [P_W-1:0]    prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [15:0]       pre1_r [H1];
  logic signed [15:0]       pre2_r [H2];
  logic signed [15:0]       g1_r [H1];
  logic signed [15:0]       g2_r [H2];
  logic [10:0]              d_r;
  logic signed [11:0]       g3_r;
  logic signed [15:0]       w_r;
  logic signed [Q_W-1:0]    q_r;

  logic signed [16:0]       mul_a, mul_b;
  logic signed [15:0]       rd_word;
  logic [DATA_W-1:0]        rdata;
  logic                     ram_we;
  logic [ADDR_W-1:0]        ram_waddr, ram_raddr;
  logic [DATA_W-1:0]        ram_wdata;
  logic signed [13:0]       diff;
  logic [CNT_W-1:0]         km1;
  logic signed [ACC_W-1:0]  acc_rnd, prod_rnd;
  logic signed [15:0]       acc_sat;
  logic [15:0]              sig_u;
  logic [16+SIG_IW:0]       sig_p;
  logic signed [Q_W-1:0]    delta, new_w;
  logic                     idx_ok, is_upd;

  assign rd_word  = signed'(rdata);
  assign diff     = signed'({1'b0, pred_r}) - signed'({1'b0, tgt_r});
  assign km1      = cmd.k - 1'b1;
  assign acc_rnd  = rnd12(acc_r);
  assign prod_rnd = rnd12(ACC_W'(prod_r));
  assign acc_sat  = sat16(Q_W'(acc_rnd));
  assign idx_ok   = (idx_r < IDX_W'(DEPTH));

  // sigmoid index: (z + 32768) * SIZE >> 16
  assign sig_u = {~acc_sat[15], acc_sat[14:0]};
  assign sig_p = (17+SIG_IW)'(sig_u) * (17+SIG_IW)'(SIG_SIZE);

  assign is_upd = (cmd.job == S_UW3) || (cmd.job == S_UB3) || (cmd.job == S_UW2) ||
                  (cmd.job == S_UB2) || (cmd.job == S_UW1) || (cmd.job == S_UB1);

  // weight step: w - rnd(lr * g * a, 24), saturated
  assign delta = (q_r + Q_W'(8388608)) >>> 24;
  assign new_w = Q_W'(w_r) - delta;

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.job)
      S_L1: begin
        mul_a = (cmd.k == '0) ? ONE_Q : 17'(feat_r[km1[0]]);
        mul_b = 17'(rd_word);
      end
      S_L2: begin
        mul_a = (cmd.k == '0) ? ONE_Q : 17'(relu(pre1_r[km1[H1_IW-1:0]]));
        mul_b = 17'(rd_word);
      end
      S_L3: begin
        mul_a = (cmd.k == '0) ? ONE_Q : 17'(relu(pre2_r[km1[H2_IW-1:0]]));
        mul_b = 17'(rd_word);
      end
      S_G2: begin
        mul_a = 17'(g3_r);
        mul_b = 17'(rd_word);
      end
      S_G1: begin
        mul_a = 17'(g2_r[cmd.k[H2_IW-1:0]]);
        mul_b = 17'(rd_word);
      end
      S_ERR: begin
        unique case (cmd.ph)
          2'd0: begin
            mul_a = signed'({4'b0, pred_r});
            mul_b = ONE_Q - signed'({4'b0, pred_r});
          end
          2'd1: begin
            mul_a = 17'(diff);
            mul_b = 17'(diff);
          end
          2'd2: begin
            mul_a = 17'(diff);
            mul_b = signed'({6'b0, d_r});
          end
          default: ;
        endcase
      end
      S_UW3: begin mul_a = 17'(g3_r); mul_b = 17'(relu(pre2_r[cmd.n[H2_IW-1:0]])); end
      S_UB3: begin mul_a = 17'(g3_r); mul_b = ONE_Q; end
      S_UW2: begin
        mul_a = 17'(g2_r[cmd.k[H2_IW-1:0]]);
        mul_b = 17'(relu(pre1_r[cmd.n[H1_IW-1:0]]));
      end
      S_UB2: begin mul_a = 17'(g2_r[cmd.k[H2_IW-1:0]]); mul_b = ONE_Q; end
      S_UW1: begin mul_a = 17'(g1_r[cmd.k[H1_IW-1:0]]); mul_b = 17'(feat_r[cmd.n[0]]); end
      S_UB1: begin mul_a = 17'(g1_r[cmd.k[H1_IW-1:0]]); mul_b = ONE_Q; end
      default: ;
    endcase
  end

  // store port control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cmd.addr;
    ram_wdata = sat16(new_w);
    ram_raddr = cmd.addr;
    if (cmd.job == S_WRITE) begin
      ram_we    = idx_ok;
      ram_waddr = idx_ok ? ADDR_W'(idx_r) : '0;
      ram_wdata = val_r;
    end else if (is_upd && cmd.ph == 2'd2) begin
      ram_we = 1'b1;
    end
    if (cmd.job == S_READ) ram_raddr = idx_ok ? ADDR_W'(idx_r) : '0;
  end

  mlp_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) lr_r <= 13'd41;
    else if (cfg_we) lr_r <= cfg_wdata;
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (cmd.accept) begin
      idx_r     <= in_word_index;
      val_r     <= in_word_value;
      feat_r[0] <= in_feature_x;
      feat_r[1] <= in_feature_y;
      tgt_r     <= (in_target_value > 13'd4096) ? 13'd4096 : in_target_value;
      pred_r    <= '0;
      rb_r      <= '0;
      sq_r      <= '0;
    end
    unique case (cmd.job)
      S_READ: begin
        if (cmd.ph == 2'd1) rb_r <= idx_ok ? rd_word : 16'sd0;
      end
      S_L1, S_L2, S_L3, S_G2, S_G1: begin
        if (cmd.ph == 2'd2) begin
          acc_r <= (cmd.k == '0) ? ACC_W'(prod_r) : acc_r + ACC_W'(prod_r);
        end else if (cmd.ph == 2'd3) begin
          unique case (cmd.job)
            S_L1: pre1_r[cmd.n[H1_IW-1:0]] <= acc_sat;
            S_L2: pre2_r[cmd.n[H2_IW-1:0]] <= acc_sat;
            S_L3: pred_r <= SIG_TAB[sig_p[16 +: SIG_IW]];
            S_G2: g2_r[cmd.n[H2_IW-1:0]] <=
                    (pre2_r[cmd.n[H2_IW-1:0]] > 16'sd0) ? acc_sat : 16'sd0;
            S_G1: g1_r[cmd.n[H1_IW-1:0]] <=
                    (pre1_r[cmd.n[H1_IW-1:0]] > 16'sd0) ? acc_sat : 16'sd0;
            default: ;
          endcase
        end
      end
      S_ERR: begin
        unique case (cmd.ph)
          2'd1: d_r  <= prod_rnd[10:0];
          2'd2: sq_r <= prod_rnd[12:0];
          2'd3: g3_r <= prod_rnd[11:0];
          default: ;
        endcase
      end
      S_UW3, S_UB3, S_UW2, S_UB2, S_UW1, S_UB1: begin
        if (cmd.ph == 2'd1) begin
          w_r <= rd_word;
          q_r <= Q_W'(signed'({1'b0, lr_r})) * Q_W'(prod_r);
        end
      end
      default: ;
    endcase
  end

  assign out_prediction    = pred_r;
  assign out_word_readback = rb_r;
  assign out_squared_error = sq_r;

endmodule

// ===== sv/mlp_infer_and_train_step_top.sv =====
// Two-layer-hidden perceptron (2-8-4-1, ReLU/ReLU/sigmoid) in Q4.12, with
// weights and biases in a 65-word store, plus one SGD training step.
//
// Input channel (in_valid / in_stall): one request per command. A request is
// taken at a clock edge with in_valid high and in_stall low. Commands: write
// a store word, read one back, infer, or train one step on (x, y, target).
// Result channel (out_valid / out_stall): exactly one result per request.
// Fields a command does not produce come back as zero.
// Configuration: cfg_we writes cfg_wdata into the learning rate (unsigned Q1.12);
// write only while no request is in flight.
//
// One request is worked at a time: a new request is not accepted until the
// result of the last one has been taken and the sequencer is back in idle.
// Work is paced by the single shared multiplier and the one store read port:
// each product takes a store read, a multiply and an accumulate step in turn.
// Reset (synchronous, active low) idles the sequencer and loads the learning
// rate with 41; store contents are undefined until written. While out_stall
// is high the result holds and in_stall stays high.
module mlp_infer_and_train_step_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_command,
  input  logic [6:0]          in_word_index,
  input  logic signed [15:0]  in_word_value,
  input  logic signed [15:0]  in_feature_x,
  input  logic signed [15:0]  in_feature_y,
  input  logic [12:0]         in_target_value,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [12:0]         out_prediction,
  output logic signed [15:0]  out_word_readback,
  output logic [12:0]         out_squared_error,
  input  logic                cfg_we,
  input  logic [12:0]         cfg_wdata
);
  import mlp_pkg::*;

  mlp_cmd_t cmd;

  // sequencer: walks layers, gradients and updates term by term
  mlp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .out_stall  (out_stall),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .cmd        (cmd)
  );

  // datapath: store, shared multiplier, accumulator, activations
  mlp_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_word_index     (in_word_index),
    .in_word_value     (in_word_value),
    .in_feature_x      (in_feature_x),
    .in_feature_y      (in_feature_y),
    .in_target_value   (in_target_value),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .out_prediction    (out_prediction),
    .out_word_readback (out_word_readback),
    .out_squared_error (out_squared_error)
  );

endmodule

// ===== tb/mlp_infer_and_train_step_checker.sv =====
`timescale 1ns / 100ps

module mlp_infer_and_train_step_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [1:0]         in_command,
  input  logic [6:0]         in_word_index,
  input  logic signed [15:0] in_word_value,
  input  logic signed [15:0] in_feature_x,
  input  logic signed [15:0] in_feature_y,
  input  logic [12:0]        in_target_value,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [12:0]        out_prediction,
  input  logic signed [15:0] out_word_readback,
  input  logic [12:0]        out_squared_error,
  input  logic               cfg_we,
  input  logic [12:0]        cfg_wdata,
  output int                 fail_count,
  output int                 pending
);
  import mlp_pkg::*;

  typedef struct {
    logic [12:0]        prediction;
    logic signed [15:0] readback;
    logic [12:0]        sq_error;
  } net_result_t;

  net_result_t  result_q[$];
  longint       net_words[DEPTH];
  longint       step_rate;
  logic [12:0]  sigmoid_lut[SIG_SIZE];

  function automatic longint round_shift(longint v, int k);
    return (v + (longint'(1) << (k - 1))) >>> k;
  endfunction

  function automatic longint clamp16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic longint descend(longint w, longint prod);
    return clamp16(w - round_shift(step_rate * prod, 24));
  endfunction

  // Sigmoid entries from a Taylor series of e^-x in Q.30.
  function automatic void fill_sigmoid();
    longint xc, sum;
    longint unsigned mag, f, term, e, den, sp;
    for (int k = 0; k < SIG_SIZE; k++) begin
      xc = longint'((longint'(k) * 65536 + 32768) / SIG_SIZE) - 32768;
      mag = (xc < 0) ? -xc : xc;
      f = mag & 4095;
      sum = longint'(1) << 30;
      term = 64'd1 << 30;
      for (int i = 1; i <= 12; i++) begin
        term = term * f / (64'd4096 * i);
        if (i % 2) sum = sum - longint'(term);
        else sum = sum + longint'(term);
      end
      e = sum;
      for (longint unsigned n = 0; n < (mag >> 12); n++)
        e = (e * 64'd395007542 + (64'd1 << 29)) >> 30;
      den = (64'd1 << 30) + e;
      sp = ((64'd4096 << 30) + den / 2) / den;
      sigmoid_lut[k] = (xc >= 0) ? 13'(sp) : 13'(64'd4096 - sp);
    end
  endfunction

  task automatic predict_request();
    net_result_t r;
    longint feat[2], pre1[H1], h1[H1], pre2[H2], h2[H2], g1[H1], g2[H2];
    longint acc, z, s, tgt, diff, d, g3;
    r = '{13'd0, 16'sd0, 13'd0};
    case (in_command)
      CMD_WRITE: begin
        if (in_word_index < DEPTH) net_words[in_word_index] = in_word_value;
      end
      CMD_READ: begin
        if (in_word_index < DEPTH) r.readback = 16'(net_words[in_word_index]);
      end
      default: begin
        feat[0] = in_feature_x;
        feat[1] = in_feature_y;
        tgt = (in_target_value > 4096) ? 4096 : in_target_value;
        for (int j = 0; j < H1; j++) begin
          acc = net_words[B1_BASE + j] * 4096;
          for (int i = 0; i < 2; i++) acc += feat[i] * net_words[W1_BASE + i * H1 + j];
          pre1[j] = clamp16(round_shift(acc, 12));
          h1[j] = (pre1[j] > 0) ? pre1[j] : 0;
        end
        for (int j = 0; j < H2; j++) begin
          acc = net_words[B2_BASE + j] * 4096;
          for (int i = 0; i < H1; i++) acc += h1[i] * net_words[W2_BASE + i * H2 + j];
          pre2[j] = clamp16(round_shift(acc, 12));
          h2[j] = (pre2[j] > 0) ? pre2[j] : 0;
        end
        acc = net_words[B3_BASE] * 4096;
        for (int i = 0; i < H2; i++) acc += h2[i] * net_words[W3_BASE + i];
        z = clamp16(round_shift(acc, 12));
        s = sigmoid_lut[((z + 32768) * SIG_SIZE) >> 16];
        r.prediction = 13'(s);
        if (in_command == CMD_TRAIN) begin
          diff = s - tgt;
          r.sq_error = 13'(round_shift(diff * diff, 12));
          d = round_shift(s * (4096 - s), 12);
          g3 = round_shift(diff * d, 12);
          // gradients use the weights from before the update
          for (int i = 0; i < H2; i++)
            g2[i] = (pre2[i] > 0) ? clamp16(round_shift(g3 * net_words[W3_BASE + i], 12)) : 0;
          for (int i = 0; i < H1; i++) begin
            acc = 0;
            for (int j = 0; j < H2; j++) acc += g2[j] * net_words[W2_BASE + i * H2 + j];
            g1[i] = (pre1[i] > 0) ? clamp16(round_shift(acc, 12)) : 0;
          end
          for (int i = 0; i < H2; i++)
            net_words[W3_BASE + i] = descend(net_words[W3_BASE + i], g3 * h2[i]);
          net_words[B3_BASE] = descend(net_words[B3_BASE], g3 * 4096);
          for (int i = 0; i < H1; i++)
            for (int j = 0; j < H2; j++)
              net_words[W2_BASE + i * H2 + j] =
                descend(net_words[W2_BASE + i * H2 + j], g2[j] * h1[i]);
          for (int j = 0; j < H2; j++)
            net_words[B2_BASE + j] = descend(net_words[B2_BASE + j], g2[j] * 4096);
          for (int i = 0; i < 2; i++)
            for (int j = 0; j < H1; j++)
              net_words[W1_BASE + i * H1 + j] =
                descend(net_words[W1_BASE + i * H1 + j], g1[j] * feat[i]);
          for (int j = 0; j < H1; j++)
            net_words[B1_BASE + j] = descend(net_words[B1_BASE + j], g1[j] * 4096);
        end
      end
    endcase
    result_q.insert(result_q.size(), r);
  endtask

  task automatic note_failure(string what, longint exp_v, longint act_v);
    if (fail_count < 10)
      $display("mismatch %s: expected %0d, got %0d", what, exp_v, act_v);
    fail_count++;
  endtask

  initial begin
    fill_sigmoid();
  end

  always @(posedge clk) begin
    net_result_t r;
    if (!rst_n) begin
      step_rate = 41;
    end else begin
      if (cfg_we) step_rate = cfg_wdata;
      if (in_valid && !in_stall) predict_request();
      if (out_valid && !out_stall) begin
        if (result_q.size() == 0) begin
          note_failure("unexpected result, prediction", -1, out_prediction);
        end else begin
          r = result_q.pop_front();
          if (out_prediction !== r.prediction)
            note_failure("prediction", r.prediction, out_prediction);
          if (out_word_readback !== r.readback)
            note_failure("word_readback", r.readback, out_word_readback);
          if (out_squared_error !== r.sq_error)
            note_failure("squared_error", r.sq_error, out_squared_error);
        end
      end
      pending <= result_q.size();
    end
  end

endmodule

// ===== tb/mlp_infer_and_train_step_top_test.sv =====
`timescale 1ns / 100ps

module mlp_infer_and_train_step_top_test;
  import mlp_pkg::*;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         in_command;
  logic [6:0]         in_word_index;
  logic signed [15:0] in_word_value;
  logic signed [15:0] in_feature_x;
  logic signed [15:0] in_feature_y;
  logic [12:0]        in_target_value;
  logic               out_valid;
  logic               out_stall;
  logic [12:0]        out_prediction;
  logic signed [15:0] out_word_readback;
  logic [12:0]        out_squared_error;
  logic               cfg_we;
  logic [12:0]        cfg_wdata;

  int  fail_count;
  int  pending;
  int  cycle_count;
  int  stall_left;
  bit  calm;

  // Roughly 650 requests, each at most as long as a train request, then several times over.
  localparam int CYCLE_LIMIT = 3000000;
  localparam int TRAIN_LATENCY = 528;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  mlp_infer_and_train_step_top u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_command        (in_command),
    .in_word_index     (in_word_index),
    .in_word_value     (in_word_value),
    .in_feature_x      (in_feature_x),
    .in_feature_y      (in_feature_y),
    .in_target_value   (in_target_value),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_prediction    (out_prediction),
    .out_word_readback (out_word_readback),
    .out_squared_error (out_squared_error),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata)
  );

  mlp_infer_and_train_step_checker u_checker (.*);

  // Hard stop in case the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("mlp_infer_and_train_step_top_test: done, errors");
      $finish;
    end
  end

  // Result-side backpressure: random stall bursts, none when calm.
  always @(posedge clk) begin
    if (!rst_n || calm) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 4) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 7);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Present one request and hold it until accepted; maybe idle afterwards.
  // Call right after a rising edge.
  task automatic send_request(logic [1:0] cmd, logic [6:0] idx, logic [15:0] val,
                              logic [15:0] fx, logic [15:0] fy, logic [12:0] tgt);
    in_valid <= 1'b1;
    in_command <= cmd;
    in_word_index <= idx;
    in_word_value <= val;
    in_feature_x <= fx;
    in_feature_y <= fy;
    in_target_value <= tgt;
    do @(posedge clk); while (in_stall);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  // Drain all results, let the sequencer settle, then load a new learning rate.
  task automatic set_rate(logic [12:0] rate);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= rate;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [15:0] pick_word();
    if ($urandom_range(0, 3) == 0) return 16'($urandom);
    return 16'($urandom_range(0, 16'h3000) - 16'h1800);
  endfunction

  function automatic logic [15:0] pick_feature();
    if ($urandom_range(0, 3) == 0) return 16'($urandom);
    return 16'($urandom_range(0, 16'h6000) - 16'h3000);
  endfunction

  function automatic logic [12:0] pick_target();
    if ($urandom_range(0, 7) == 0) return 13'($urandom);
    return 13'($urandom_range(0, 4096));
  endfunction

  task automatic random_phase(int count);
    int r;
    logic [6:0] idx;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      idx = ($urandom_range(0, 7) == 0) ? 7'($urandom) : 7'($urandom_range(0, DEPTH - 1));
      if (r < 40)
        send_request(CMD_TRAIN, 7'($urandom), 16'($urandom), pick_feature(),
                     pick_feature(), pick_target());
      else if (r < 65)
        send_request(CMD_INFER, 7'($urandom), 16'($urandom), pick_feature(),
                     pick_feature(), pick_target());
      else if (r < 85)
        send_request(CMD_WRITE, idx, pick_word(), 16'($urandom), 16'($urandom),
                     13'($urandom));
      else
        send_request(CMD_READ, idx, 16'($urandom), 16'($urandom), 16'($urandom),
                     13'($urandom));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_command = CMD_WRITE;
    in_word_index = '0;
    in_word_value = '0;
    in_feature_x = '0;
    in_feature_y = '0;
    in_target_value = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    calm = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fill the whole store first so nothing unwritten is ever read.
    for (int i = 0; i < DEPTH; i++)
      send_request(CMD_WRITE, 7'(i), pick_word(), 16'h0, 16'h0, 13'h0);

    // Directed: extreme words, out-of-range index, extreme features and targets.
    send_request(CMD_WRITE, 7'(B3_BASE), 16'sh7fff, 16'h0, 16'h0, 13'h0);
    send_request(CMD_READ,  7'(B3_BASE), 16'h0, 16'h0, 16'h0, 13'h0);
    send_request(CMD_WRITE, 7'(W1_BASE), 16'sh8000, 16'h0, 16'h0, 13'h0);
    send_request(CMD_READ,  7'(W1_BASE), 16'hffff, 16'h0, 16'h0, 13'h0);
    send_request(CMD_WRITE, 7'h7f, 16'h5555, 16'h0, 16'h0, 13'h0);
    send_request(CMD_READ,  7'h7f, 16'h0, 16'h0, 16'h0, 13'h0);
    send_request(CMD_READ,  7'(DEPTH), 16'h0, 16'h0, 16'h0, 13'h0);
    send_request(CMD_INFER, 7'h0, 16'h0, 16'sh7fff, 16'sh7fff, 13'h0);
    send_request(CMD_INFER, 7'h0, 16'h0, 16'sh8000, 16'sh8000, 13'h1fff);
    send_request(CMD_INFER, 7'h0, 16'h0, 16'h0, 16'h0, 13'h0);
    send_request(CMD_TRAIN, 7'h0, 16'h0, 16'h1000, 16'hf000, 13'd0);
    send_request(CMD_TRAIN, 7'h0, 16'h0, 16'h0800, 16'h0400, 13'd4096);
    send_request(CMD_TRAIN, 7'h0, 16'h0, 16'sh7fff, 16'sh8000, 13'h1fff);
    send_request(CMD_WRITE, 7'(B3_BASE), 16'sh8000, 16'h0, 16'h0, 13'h0);
    send_request(CMD_TRAIN, 7'h7f, 16'hffff, 16'h2000, 16'h2000, 13'd2048);

    // Sweep the learning rate across its extremes between random phases.
    set_rate(13'd8191);
    random_phase(114);
    set_rate(13'd0);
    random_phase(114);
    set_rate(13'd4096);
    random_phase(114);
    set_rate(13'($urandom));
    random_phase(114);
    set_rate(13'd41);
    calm = 1'b1;
    random_phase(114);

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (TRAIN_LATENCY) @(posedge clk);
    if (fail_count == 0) begin
      $display("mlp_infer_and_train_step_top_test: done, clean");
    end else begin
      $display("mlp_infer_and_train_step_top_test: done, errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/mlp_pkg.sv
sv/mlp_ram.sv
sv/mlp_ctrl.sv
sv/mlp_dp.sv
sv/mlp_infer_and_train_step_top.sv
tb/mlp_infer_and_train_step_checker.sv
tb/mlp_infer_and_train_step_top_test.sv
